// ----- rtl/core/bcta_pkg.sv -----
// bcta_pkg: shared types, constants and the bcd digit decode for the cell time accumulator
// no dependencies

package bcta_pkg;

  localparam int NS_W    = 49;
  localparam int COUNT_W = 24;
  localparam int QUOT_W  = 24;

  localparam logic [24:0] NTSC_QUOT    = 25'd33366666;
  localparam logic [25:0] PAL_NS       = 26'd40000000;
  localparam logic [31:0] THIRD_RECIP  = 32'hAAAAAAAB;
  localparam logic [7:0]  BCD_MAX      = 8'd99;
  localparam logic [23:0] HOUR_FRAMES  = 24'd108000;
  localparam logic [23:0] MIN_FRAMES   = 24'd1800;
  localparam logic [23:0] SEC_FRAMES   = 24'd30;
  localparam logic [62:0] NS_MAX       = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [8:0]  PROG_MAX     = 9'd255;
  localparam logic [8:0]  CHAPTER_BASE = 9'd2;

  typedef struct packed {
    logic [NS_W-1:0] ns;
    logic            program_end;
    logic            title_start;
  } cell_t;

  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// ----- rtl/core/bcta_core_top.sv -----
// Cell time accumulator: one cell request is accepted per clock while the queue has room, so
// the sustained rate is one cell per cycle. A cell takes two front stages (bcd decode and frame
// count, then the nanosecond multiply) before it enters the queue, and the back accumulates one
// queued cell per cycle with a saturating add; a result is registered when the back takes the last
// cell of a program. The queue of QUEUE_DEPTH entries, counted together with the cells
// still in the front stages, sets when in_stall rises; a stalled result only holds back cells
// that end a program. After reset the block takes requests at once.
// depends on bcta_pkg, bcta_front, bcta_queue, bcta_back

module bcd_cell_time_accumulator_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cell_kind,
  input  logic [31:0] bcd_time,
  input  logic        program_end,
  input  logic        title_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] running_ns,
  output logic [8:0]  chapter_number
);

  localparam int CW = $clog2(QUEUE_DEPTH+1);
  localparam logic [CW+1:0] DEPTH_C = (CW+2)'(QUEUE_DEPTH);

  logic                 accept;
  logic                 push;
  bcta_pkg::cell_t      push_cell;
  logic [1:0]           inflight;
  logic                 pop;
  bcta_pkg::cell_t      head;
  logic                 nonempty;
  logic [CW-1:0]        q_count;
  logic [CW+1:0]        occupancy;

  assign occupancy = {2'b00, q_count} + {{CW{1'b0}}, inflight};
  assign in_stall  = (occupancy >= DEPTH_C);
  assign accept    = in_valid && !in_stall;

  bcta_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cell_kind   (cell_kind),
    .bcd_time    (bcd_time),
    .program_end (program_end),
    .title_start (title_start),
    .push        (push),
    .entry       (push_cell),
    .inflight    (inflight)
  );

  bcta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cell (push_cell),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty),
    .count     (q_count)
  );

  bcta_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .nonempty       (nonempty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .running_ns     (running_ns),
    .chapter_number (chapter_number)
  );

  a_occupancy: assert property (@(posedge clk) disable iff (rst) occupancy <= DEPTH_C)
    else $error("queued and in-flight cells exceed queue depth");
  a_accept_lands: assert property (@(posedge clk) disable iff (rst) accept |=> ##1 push)
    else $error("accepted cell did not reach the queue");

endmodule

// ----- rtl/core/bcta_front.sv -----
// bcta_front: decodes each accepted cell and converts its playback time to nanoseconds
// two register stages; depends on bcta_pkg

module bcta_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          cell_kind,
  input  logic [31:0]         bcd_time,
  input  logic                program_end,
  input  logic                title_start,
  output logic                push,
  output bcta_pkg::cell_t     entry,
  output logic [1:0]          inflight
);

  logic [7:0] hours;
  logic [7:0] minutes;
  logic [7:0] seconds;
  logic [7:0] frames;
  logic       has_time;
  logic [bcta_pkg::COUNT_W-1:0] count_next;

  logic                         v1;
  logic [bcta_pkg::COUNT_W-1:0] count1;
  logic                         ntsc1;
  logic                         time1;
  logic                         end1;
  logic                         start1;

  logic [24:0]                 recip_y;
  logic [56:0]                 recip_prod;
  logic [bcta_pkg::NS_W-1:0]   main_next;

  logic                         v2;
  logic [bcta_pkg::NS_W-1:0]    main2;
  logic [bcta_pkg::QUOT_W-1:0]  quot2;
  logic                         end2;
  logic                         start2;

  always_comb begin
    hours    = bcta_pkg::bcd_byte(bcd_time[31:24]);
    minutes  = bcta_pkg::bcd_byte(bcd_time[23:16]);
    seconds  = bcta_pkg::bcd_byte(bcd_time[15:8]);
    frames   = bcta_pkg::bcd_byte({2'b00, bcd_time[5:0]});
    has_time = !cell_kind[1] && bcd_time[6] && (hours <= bcta_pkg::BCD_MAX) &&
               (minutes <= bcta_pkg::BCD_MAX) && (seconds <= bcta_pkg::BCD_MAX);
    count_next = {16'd0, hours} * bcta_pkg::HOUR_FRAMES +
                 {16'd0, minutes} * bcta_pkg::MIN_FRAMES +
                 {16'd0, seconds} * bcta_pkg::SEC_FRAMES + {16'd0, frames};
  end

  // ntsc: count * 1001000000 / 30 split as count * quot + (2 * count + 1) / 3
  always_comb begin
    recip_y    = {count1, 1'b1};
    recip_prod = {32'd0, recip_y} * {25'd0, bcta_pkg::THIRD_RECIP};
    if (ntsc1) begin
      main_next = {25'd0, count1} * {24'd0, bcta_pkg::NTSC_QUOT};
    end else begin
      main_next = {25'd0, count1} * {23'd0, bcta_pkg::PAL_NS};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    count1 <= count_next;
    ntsc1  <= bcd_time[7];
    time1  <= has_time;
    end1   <= program_end;
    start1 <= title_start;
    main2  <= time1 ? main_next : '0;
    quot2  <= (time1 && ntsc1) ? recip_prod[56:33] : '0;
    end2   <= end1;
    start2 <= start1;
  end

  assign push              = v2;
  assign entry.ns          = main2 + {{(bcta_pkg::NS_W-bcta_pkg::QUOT_W){1'b0}}, quot2};
  assign entry.program_end = end2;
  assign entry.title_start = start2;
  assign inflight          = {1'b0, v1} + {1'b0, v2};

endmodule

// ----- rtl/core/bcta_queue.sv -----
// bcta_queue: short first-in first-out queue of converted cells between front and back
// register array with one read pointer; depends on bcta_pkg

module bcta_queue #(
  parameter int DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bcta_pkg::cell_t               push_cell,
  input  logic                          pop,
  output bcta_pkg::cell_t               head,
  output logic                          nonempty,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LAST   = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  bcta_pkg::cell_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            full;

  assign nonempty = (count != '0);
  assign full     = (count == FULL_C);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cell;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue read while empty");

endmodule

// ----- rtl/core/bcta_back.sv -----
// bcta_back: saturating accumulation of cell times and the result register
// takes cells from the queue head; depends on bcta_pkg

module bcta_back (
  input  logic              clk,
  input  logic              rst,
  input  bcta_pkg::cell_t   head,
  input  logic              nonempty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [62:0]       running_ns,
  output logic [8:0]        chapter_number
);

  logic [62:0] total;
  logic [8:0]  prog_count;
  logic [62:0] base;
  logic [63:0] sum;
  logic [62:0] total_next;
  logic [8:0]  prog_base;
  logic [8:0]  prog_count_next;
  logic        out_valid_next;

  always_comb begin
    base       = head.title_start ? '0 : total;
    prog_base  = head.title_start ? '0 : prog_count;
    sum        = {1'b0, base} + {{(64-bcta_pkg::NS_W){1'b0}}, head.ns};
    total_next = sum[63] ? bcta_pkg::NS_MAX : sum[62:0];
    pop        = nonempty && (!head.program_end || !out_valid || !out_stall);
  end

  always_comb begin
    prog_count_next = prog_count;
    out_valid_next  = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (pop) begin
      prog_count_next = prog_base;
      if (head.program_end) begin
        out_valid_next = 1'b1;
        if (prog_base < bcta_pkg::PROG_MAX) begin
          prog_count_next = prog_base + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      prog_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        total <= total_next;
      end
      prog_count <= prog_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.program_end) begin
      running_ns     <= total_next;
      chapter_number <= prog_base + bcta_pkg::CHAPTER_BASE;
    end
  end

  a_prog_sat: assert property (@(posedge clk) disable iff (rst)
    prog_count <= bcta_pkg::PROG_MAX)
    else $error("program count beyond saturation");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(pop && head.program_end))
    else $error("pending result overwritten");

endmodule

// ----- verif/bcta_chapter_checker.sv -----
// bcta_chapter_checker: watches the cell and chapter channels of the cell time accumulator,
// predicts each chapter mark from the accepted cell requests and compares it field by field
// depends on bcta_pkg
module bcta_chapter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cell_kind,
  input  logic [31:0] bcd_time,
  input  logic        program_end,
  input  logic        title_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [62:0] running_ns,
  input  logic [8:0]  chapter_number,
  output int          fail_total,
  output int          marks_due
);

  typedef struct packed {
    logic [62:0] ns;
    logic [8:0]  chapter;
  } chapter_mark_t;

  chapter_mark_t due_marks[$];
  chapter_mark_t want;
  chapter_mark_t mark;
  logic [62:0]   title_ns;
  logic [8:0]    programs_done;
  int            errors;

  function automatic int unsigned bcd_pair(logic [7:0] b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  function automatic logic [63:0] cell_duration(logic [31:0] t);
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    logic [63:0] frames;
    hh = bcd_pair(t[31:24]);
    mm = bcd_pair(t[23:16]);
    ss = bcd_pair(t[15:8]);
    // rate flag without bit 6, or a clock field decoding above 99
    if (!t[6] || hh > 99 || mm > 99 || ss > 99) return 64'd0;
    frames = 64'(bcd_pair({2'b00, t[5:0]}));
    frames = frames + 64'((hh * 3600 + mm * 60 + ss) * 30);
    if (t[7]) return (frames * 64'd1001000000 + 64'd15) / 64'd30;
    return frames * 64'd40000000;
  endfunction

  function automatic logic [62:0] add_capped(logic [62:0] acc, logic [63:0] ns);
    logic [63:0] sum;
    sum = {1'b0, acc} + ns;
    return (sum > {1'b0, bcta_pkg::NS_MAX}) ? bcta_pkg::NS_MAX : sum[62:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      due_marks.delete();
      title_ns = '0;
      programs_done = '0;
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_marks.size() == 0) begin
          $error("unexpected chapter mark: running_ns %0d chapter_number %0d",
                 running_ns, chapter_number);
          errors++;
        end else begin
          want = due_marks.pop_front();
          if (running_ns !== want.ns) begin
            $error("running_ns expected %0d actual %0d", want.ns, running_ns);
            errors++;
          end
          if (chapter_number !== want.chapter) begin
            $error("chapter_number expected %0d actual %0d", want.chapter, chapter_number);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (title_start) begin
          title_ns = '0;
          programs_done = '0;
        end
        // normal and first-angle cells carry a time
        if (!cell_kind[1]) title_ns = add_capped(title_ns, cell_duration(bcd_time));
        if (program_end) begin
          mark.ns = title_ns;
          mark.chapter = programs_done + bcta_pkg::CHAPTER_BASE;
          due_marks.push_back(mark);
          if (programs_done < bcta_pkg::PROG_MAX) programs_done++;
        end
      end
    end
    fail_total <= errors;
    marks_due <= due_marks.size();
  end

endmodule

// ----- verif/bcd_cell_time_accumulator_core_tb.sv -----
// bcd_cell_time_accumulator_core_tb: drives cell requests into the accumulator core through
// idle, stall and hold-off phases and gives the verdict from the chapter checker
// depends on bcta_pkg, bcd_cell_time_accumulator_core, bcta_chapter_checker
module bcd_cell_time_accumulator_core_tb;

  localparam logic [1:0] KIND_NORMAL      = 2'd0;
  localparam logic [1:0] KIND_ANGLE_FIRST = 2'd1;
  localparam logic [1:0] KIND_ANGLE_MID   = 2'd2;
  localparam logic [1:0] KIND_ANGLE_LAST  = 2'd3;

  localparam logic [1:0] RATE_NONE = 2'b00;
  localparam logic [1:0] RATE_PAL  = 2'b01;
  localparam logic [1:0] RATE_RSVD = 2'b10;
  localparam logic [1:0] RATE_NTSC = 2'b11;

  localparam logic [31:0] PAL_MAX_TIME = 32'h9999_997F;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MIX_CELLS      = 200;
  localparam int SATURATE_CELLS = 270;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cell_kind = '0;
  logic [31:0] bcd_time = '0;
  logic        program_end = 1'b0;
  logic        title_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [62:0] running_ns;
  logic [8:0]  chapter_number;

  int fail_total;
  int marks_due;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_serial = 0;
  int hold_seen = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bcd_cell_time_accumulator_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cell_kind(cell_kind),
    .bcd_time(bcd_time),
    .program_end(program_end),
    .title_start(title_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .running_ns(running_ns),
    .chapter_number(chapter_number)
  );

  bcta_chapter_checker chapter_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cell_kind(cell_kind),
    .bcd_time(bcd_time),
    .program_end(program_end),
    .title_start(title_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .running_ns(running_ns),
    .chapter_number(chapter_number),
    .fail_total(fail_total),
    .marks_due(marks_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] to_bcd(int unsigned v);
    logic [7:0] b;
    b[7:4] = 4'(v / 10);
    b[3:0] = 4'(v % 10);
    return b;
  endfunction

  function automatic logic [31:0] pack_time(int unsigned hh, int unsigned mm, int unsigned ss,
                                            logic [1:0] rate, int unsigned ff);
    logic [7:0] fb;
    fb = to_bcd(ff);
    return {to_bcd(hh), to_bcd(mm), to_bcd(ss), rate, fb[5:0]};
  endfunction

  function automatic logic [1:0] random_kind();
    if ($urandom_range(15) == 0) return 2'($urandom_range(KIND_ANGLE_LAST, KIND_ANGLE_MID));
    return 2'($urandom_range(KIND_ANGLE_FIRST, KIND_NORMAL));
  endfunction

  function automatic logic [31:0] random_time();
    logic [31:0] t;
    logic [1:0]  rate;
    int unsigned pick;
    int unsigned lane;
    pick = $urandom_range(15);
    lane = 8 * $urandom_range(3, 1);
    if (pick == 0) return $urandom;
    rate = $urandom_range(1) ? RATE_NTSC : RATE_PAL;
    t = pack_time($urandom_range(99), $urandom_range(99), $urandom_range(99), rate,
                  $urandom_range(39));
    // untimed rate flag, clock field above 99, or a digit above 9 that still decodes small
    if (pick == 1) t[7:6] = $urandom_range(1) ? RATE_NONE : RATE_RSVD;
    if (pick == 2) t[lane +: 8] = 8'($urandom_range(255, 154));
    if (pick == 3) t[lane +: 8] = 8'($urandom_range(8) * 16 + $urandom_range(15, 10));
    return t;
  endfunction

  task automatic send_cell(input logic [1:0] kind, input logic [31:0] t, input logic pend,
                           input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_kind <= kind;
    bcd_time <= t;
    program_end <= pend;
    title_start <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (marks_due != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int sent;
    int span;
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cell(KIND_NORMAL, pack_time(0, 0, 0, RATE_NTSC, 0), 1'b1, 1'b1);
    send_cell(KIND_NORMAL, pack_time(0, 0, 0, RATE_NTSC, 1), 1'b0, 1'b1);
    send_cell(KIND_ANGLE_FIRST, pack_time(0, 0, 1, RATE_PAL, 0), 1'b1, 1'b0);
    send_cell(KIND_NORMAL, {8'h99, 8'h99, 8'h99, RATE_NTSC, 6'h3F}, 1'b0, 1'b1);
    send_cell(KIND_ANGLE_FIRST, PAL_MAX_TIME, 1'b1, 1'b0);
    send_cell(KIND_ANGLE_MID, pack_time(1, 2, 3, RATE_NTSC, 4), 1'b1, 1'b0);
    send_cell(KIND_ANGLE_LAST, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_cell(KIND_NORMAL, pack_time(12, 34, 56, RATE_NONE, 7), 1'b0, 1'b0);
    send_cell(KIND_NORMAL, pack_time(12, 34, 56, RATE_RSVD, 7), 1'b1, 1'b0);
    send_cell(KIND_NORMAL, {8'hA0, 8'h00, 8'h00, RATE_NTSC, 6'h00}, 1'b0, 1'b1);
    send_cell(KIND_ANGLE_FIRST, {8'h00, 8'h9A, 8'h00, RATE_PAL, 6'h01}, 1'b0, 1'b0);
    send_cell(KIND_NORMAL, {8'h00, 8'h00, 8'hF0, RATE_NTSC, 6'h02}, 1'b1, 1'b0);
    send_cell(KIND_NORMAL, {8'h0F, 8'h5F, 8'h99, RATE_NTSC, 6'h2F}, 1'b1, 1'b0);
    send_cell(KIND_NORMAL, 32'h0000_0000, 1'b0, 1'b0);
    send_cell(KIND_NORMAL, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_cell(KIND_ANGLE_FIRST, pack_time(1, 0, 0, RATE_PAL, 0), 1'b1, 1'b1);
    send_cell(KIND_NORMAL, pack_time(99, 59, 59, RATE_NTSC, 29), 1'b1, 1'b0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct = 31;
        end
      endcase
      sent = 0;
      while (sent < MIX_CELLS) begin
        span = $urandom_range(8, 1);
        for (i = 0; i < span; i++)
          send_cell(random_kind(), random_time(),
                    (i == span - 1 && $urandom_range(7) != 0) || $urandom_range(3) == 0,
                    i == 0 || $urandom_range(31) == 0);
        sent += span;
      end
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    hold_serial++;
    for (i = 0; i < 24; i++) send_cell(random_kind(), random_time(), 1'b1, i == 0);
    wait_drained();

    // one long title of full-length cells, each ending a program, drives the chapter count to
    // its cap
    for (i = 0; i < SATURATE_CELLS; i++)
      send_cell(2'($urandom_range(KIND_ANGLE_FIRST, KIND_NORMAL)), PAL_MAX_TIME, 1'b1, i == 0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_total == 0 && marks_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
